// ----- sv/hob_pkg.sv -----
// ----------------------------------------------------------------------------
// hob_pkg
// Shared types, register codes, reset values and the colormap for the
// heatmap overlay blend block.
// ----------------------------------------------------------------------------
package hob_pkg;

  // default number of grid cells held in the intensity store
  localparam int unsigned GRID_CELLS_DEF = 1024;
  // width of a cell address carried through the queue (covers up to 4096 cells)
  localparam int unsigned IDX_W = 12;
  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH = 3'd0,
    CFG_CELL_WIDTH  = 3'd1,
    CFG_CELL_HEIGHT = 3'd2,
    CFG_GRID_WIDTH  = 3'd3,
    CFG_GRID_HEIGHT = 3'd4,
    CFG_LEVEL_FLOOR = 3'd5,
    CFG_RANGE_SCALE = 3'd6,
    CFG_ALPHA       = 3'd7
  } hob_cfg_idx_e;

  // item kinds
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } hob_req_e;

  // reset values of the registers
  localparam logic [11:0] RST_FRAME_WIDTH = 12'd320;
  localparam logic [7:0]  RST_CELL_WIDTH  = 8'd20;
  localparam logic [7:0]  RST_CELL_HEIGHT = 8'd20;
  localparam logic [5:0]  RST_GRID_WIDTH  = 6'd16;
  localparam logic [5:0]  RST_GRID_HEIGHT = 6'd12;
  localparam logic [31:0] RST_LEVEL_FLOOR = 32'd0;
  localparam logic [4:0]  RST_RANGE_SCALE = 5'd8;
  localparam logic [8:0]  RST_ALPHA       = 9'd128;

  // full alpha weight
  localparam logic [8:0] ALPHA_FULL = 9'd256;

  typedef struct packed {
    logic [11:0]        frame_width;
    logic [7:0]         cell_width;
    logic [7:0]         cell_height;
    logic [5:0]         grid_width;
    logic [5:0]         grid_height;
    logic signed [31:0] level_floor;
    logic [4:0]         range_scale;
    logic [8:0]         alpha;
  } hob_cfg_t;

  // one queue entry: a classified load or pixel item
  typedef struct packed {
    hob_req_e         kind;
    logic             ok;     // load in range, or pixel in a stored grid cell
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
    logic [15:0]      pixel;
  } hob_qent_t;

  typedef struct packed {
    logic [5:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } hob_rgb_t;

  // blue-green-red colormap of an 8-bit level
  function automatic hob_rgb_t hob_colormap(input logic [7:0] n);
    hob_rgb_t c;
    logic [7:0] t;
    c = '0;
    if (n > 8'd127) begin
      t   = n - 8'd127;
      c.r = 6'(t >> 2);
      t   = 8'd255 - n;
      c.g = 6'(t >> 1);
      c.b = 5'd0;
    end else begin
      c.r = 6'd0;
      c.g = 6'(n >> 1);
      t   = 8'd127 - n;
      c.b = 5'(t >> 2);
    end
    return c;
  endfunction

endpackage

// ----- sv/heatmap_overlay_blend.sv -----
// ----------------------------------------------------------------------------
// heatmap_overlay_blend
// Overlays a coarse grid of sound intensities onto an RGB565 pixel stream.
//
//   channel   direction  handshake          payload
//   in        input      valid_i / stall_o  req_type, cell_index, intensity,
//                                           pixel, frame_start
//   out       output     valid_o / stall_i  pixel_out
//   cfg       input      cfg_we_i           cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output does not stall; a pixel
// passes through the queue, store read, difference, scale and blend registers.
// Loads take a queue slot and the store write port but give no result.
// Reset clears the raster counters, queue and pipeline valids; the
// intensity store is not cleared and needs no clearing pass.
// A stall on a valid output freezes the back pipeline; the two-entry queue
// then fills and the input stalls.
// ----------------------------------------------------------------------------
module heatmap_overlay_blend #(
  parameter int unsigned GRID_CELLS = hob_pkg::GRID_CELLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  // input items
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               req_type_i,
  input  logic [9:0]         cell_index_i,
  input  logic signed [31:0] intensity_i,
  input  logic [15:0]        pixel_i,
  input  logic               frame_start_i,
  // result items
  output logic               valid_o,
  input  logic               stall_i,
  output logic [15:0]        pixel_out_o
);
  import hob_pkg::*;

  hob_cfg_t  cfg_q;
  hob_qent_t front_ent, head;
  logic      q_full, q_empty, pop;
  logic      accept;

  assign stall_o = q_full;
  assign accept  = valid_i && !q_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width <= RST_FRAME_WIDTH;
      cfg_q.cell_width  <= RST_CELL_WIDTH;
      cfg_q.cell_height <= RST_CELL_HEIGHT;
      cfg_q.grid_width  <= RST_GRID_WIDTH;
      cfg_q.grid_height <= RST_GRID_HEIGHT;
      cfg_q.level_floor <= RST_LEVEL_FLOOR;
      cfg_q.range_scale <= RST_RANGE_SCALE;
      cfg_q.alpha       <= RST_ALPHA;
    end else if (cfg_we_i) begin
      unique case (hob_cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data_i[11:0];
        CFG_CELL_WIDTH:  cfg_q.cell_width  <= cfg_data_i[7:0];
        CFG_CELL_HEIGHT: cfg_q.cell_height <= cfg_data_i[7:0];
        CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data_i[5:0];
        CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_data_i[5:0];
        CFG_LEVEL_FLOOR: cfg_q.level_floor <= cfg_data_i;
        CFG_RANGE_SCALE: cfg_q.range_scale <= cfg_data_i[4:0];
        CFG_ALPHA:       cfg_q.alpha       <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // front: counters and classification
  hob_front #(
    .GRID_CELLS(GRID_CELLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .cell_index_i (cell_index_i),
    .intensity_i  (intensity_i),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .ent_o        (front_ent)
  );

  // queue between front and back
  hob_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .push_ent_i(front_ent),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (head)
  );

  // back: store and blend pipeline
  hob_back #(
    .GRID_CELLS(GRID_CELLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .pixel_out_o(pixel_out_o)
  );

endmodule

// ----- sv/hob_front.sv -----
// ----------------------------------------------------------------------------
// hob_front
// Accepts items, keeps the raster counters and classifies each item into
// a queue entry (load address check, pixel cell lookup).
// ----------------------------------------------------------------------------
module hob_front #(
  parameter int unsigned GRID_CELLS = hob_pkg::GRID_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hob_pkg::hob_cfg_t   cfg_i,
  input  logic                accept_i,
  input  logic                req_type_i,
  input  logic [9:0]          cell_index_i,
  input  logic signed [31:0]  intensity_i,
  input  logic [15:0]         pixel_i,
  input  logic                frame_start_i,
  output hob_pkg::hob_qent_t  ent_o
);
  import hob_pkg::*;

  localparam logic [12:0] CELLS13 = 13'(GRID_CELLS);

  logic [11:0] col_q, col_d, row_q, row_d;
  logic [5:0]  cc_q, cc_d, cr_q, cr_d;
  logic [7:0]  ox_q, ox_d, oy_q, oy_d;

  logic [11:0] cur_col, cur_row;
  logic [5:0]  cur_cc, cur_cr;
  logic [7:0]  cur_ox, cur_oy;
  logic [11:0] row_prod;
  logic [12:0] grid_idx;
  logic        in_grid;
  logic        is_pix;

  function automatic logic [5:0] sat_inc6(input logic [5:0] v);
    return (v == 6'h3F) ? v : v + 6'd1;
  endfunction

  assign is_pix = (req_type_i == REQ_PIXEL);

  // counters as seen by this pixel, and their next values
  always_comb begin
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    cur_cc  = frame_start_i ? '0 : cc_q;
    cur_cr  = frame_start_i ? '0 : cr_q;
    cur_ox  = frame_start_i ? '0 : ox_q;
    cur_oy  = frame_start_i ? '0 : oy_q;

    col_d = cur_col;
    row_d = cur_row;
    cc_d  = cur_cc;
    cr_d  = cur_cr;
    ox_d  = cur_ox;
    oy_d  = cur_oy;
    if (({1'b0, cur_col} + 13'd1) >= {1'b0, cfg_i.frame_width}) begin
      col_d = '0;
      ox_d  = '0;
      cc_d  = '0;
      row_d = cur_row + 12'd1;
      if (({1'b0, cur_oy} + 9'd1) >= {1'b0, cfg_i.cell_height}) begin
        oy_d = '0;
        cr_d = sat_inc6(cur_cr);
      end else begin
        oy_d = cur_oy + 8'd1;
      end
    end else begin
      col_d = cur_col + 12'd1;
      if (({1'b0, cur_ox} + 9'd1) >= {1'b0, cfg_i.cell_width}) begin
        ox_d = '0;
        cc_d = sat_inc6(cur_cc);
      end else begin
        ox_d = cur_ox + 8'd1;
      end
    end
  end

  // row-major cell index of the current pixel
  always_comb begin
    row_prod = {6'd0, cur_cr} * {6'd0, cfg_i.grid_width};
    grid_idx = {1'b0, row_prod} + {7'd0, cur_cc};
    in_grid  = (cur_cc < cfg_i.grid_width) && (cur_cr < cfg_i.grid_height);
  end

  // queue entry
  always_comb begin
    ent_o.kind  = is_pix ? REQ_PIXEL : REQ_LOAD;
    ent_o.data  = intensity_i;
    ent_o.pixel = pixel_i;
    if (is_pix) begin
      ent_o.ok   = in_grid && (grid_idx < CELLS13);
      ent_o.addr = grid_idx[IDX_W-1:0];
    end else begin
      ent_o.ok   = ({3'd0, cell_index_i} < CELLS13);
      ent_o.addr = IDX_W'(cell_index_i);
    end
  end

  // raster counters advance on pixel items only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cc_q  <= '0;
      cr_q  <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (accept_i && is_pix) begin
      col_q <= col_d;
      row_q <= row_d;
      cc_q  <= cc_d;
      cr_q  <= cr_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
    end
  end

endmodule

// ----- sv/hob_queue.sv -----
// ----------------------------------------------------------------------------
// hob_queue
// Short queue between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module hob_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hob_pkg::hob_qent_t push_ent_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hob_pkg::hob_qent_t head_o
);
  import hob_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  hob_qent_t       mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_ent_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != CW'(QDEPTH))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("queue count did not follow push");
`endif

endmodule

// ----- sv/hob_back.sv -----
// ----------------------------------------------------------------------------
// hob_back
// Carries out queued items: writes the intensity store for loads, and for
// pixels reads the cell, maps the level to a colour and blends it in.
// ----------------------------------------------------------------------------
module hob_back #(
  parameter int unsigned GRID_CELLS = hob_pkg::GRID_CELLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hob_pkg::hob_cfg_t  cfg_i,
  input  logic               empty_i,
  input  hob_pkg::hob_qent_t head_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [15:0]        pixel_out_o
);
  import hob_pkg::*;

  localparam int unsigned AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

  logic [31:0] mem [GRID_CELLS];

  logic        en;
  logic        wr_en;

  // stage 1: store read
  logic        s1_v_q;
  logic        s1_ok_q;
  logic [15:0] s1_pix_q;
  logic [31:0] rdata_q;
  // stage 2: difference to level floor
  logic        s2_v_q;
  logic        s2_bl_q, s2_bl_d;
  logic [15:0] s2_pix_q;
  logic [31:0] s2_diff_q;
  logic [32:0] diff33;
  // stage 3: clamp, scale, colormap
  logic        s3_v_q;
  logic        s3_bl_q;
  logic [15:0] s3_pix_q;
  hob_rgb_t    s3_rgb_q, s3_rgb_d;
  logic [32:0] mask33;
  logic [31:0] mask, dclamp, shl, shr;
  logic [4:0]  sh_l, sh_r;
  logic [7:0]  lvl;
  // output stage: blend
  logic        out_v_q;
  logic [15:0] out_q, out_d;
  logic [8:0]  a_w, a_inv;
  logic [15:0] r_sum, g_sum, b_sum;

  assign en     = !(out_v_q && stall_i);
  assign pop_o  = en && !empty_i;
  assign wr_en  = pop_o && (head_i.kind == REQ_LOAD) && head_i.ok;

  // intensity store write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[head_i.addr[AW-1:0]] <= head_i.data;
    end
  end

  // intensity store read
  always_ff @(posedge clk_i) begin
    if (en) begin
      rdata_q <= mem[head_i.addr[AW-1:0]];
    end
  end

  // level above the floor, formed exactly
  always_comb begin
    diff33  = {rdata_q[31], rdata_q} - {cfg_i.level_floor[31], cfg_i.level_floor};
    s2_bl_d = s1_ok_q && !diff33[32];
  end

  // clamp to the range and scale to eight bits
  always_comb begin
    mask33 = (33'd1 << cfg_i.range_scale) - 33'd1;
    mask   = mask33[31:0];
    dclamp = (|(s2_diff_q & ~mask)) ? mask : s2_diff_q;
    sh_l   = 5'd8 - cfg_i.range_scale;
    sh_r   = cfg_i.range_scale - 5'd8;
    shl    = dclamp << sh_l;
    shr    = dclamp >> sh_r;
    lvl    = (cfg_i.range_scale < 5'd8) ? shl[7:0] : shr[7:0];
    s3_rgb_d = hob_colormap(lvl);
  end

  // alpha blend and pack, red carry lost at the pack
  always_comb begin
    a_w   = (cfg_i.alpha > ALPHA_FULL) ? ALPHA_FULL : cfg_i.alpha;
    a_inv = ALPHA_FULL - a_w;
    r_sum = ({7'd0, a_inv} * {10'd0, s3_rgb_q.r}) + ({7'd0, a_w} * {11'd0, s3_pix_q[15:11]});
    g_sum = ({7'd0, a_inv} * {10'd0, s3_rgb_q.g}) + ({7'd0, a_w} * {10'd0, s3_pix_q[10:5]});
    b_sum = ({7'd0, a_inv} * {11'd0, s3_rgb_q.b}) + ({7'd0, a_w} * {11'd0, s3_pix_q[4:0]});
    out_d = s3_bl_q ? {r_sum[12:8], g_sum[13:8], b_sum[12:8]} : s3_pix_q;
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= pop_o && (head_i.kind == REQ_PIXEL);
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ok_q   <= head_i.ok;
      s1_pix_q  <= head_i.pixel;
      s2_bl_q   <= s2_bl_d;
      s2_pix_q  <= s1_pix_q;
      s2_diff_q <= diff33[31:0];
      s3_bl_q   <= s2_bl_q;
      s3_pix_q  <= s2_pix_q;
      s3_rgb_q  <= s3_rgb_d;
      out_q     <= out_d;
    end
  end

  assign valid_o     = out_v_q;
  assign pixel_out_o = out_q;

`ifndef SYNTHESIS
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> !s1_v_q)
    else $error("load item produced a pipeline entry");
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s1_v_q |=> s2_v_q)
    else $error("pixel lost between store read and difference stage");
  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s3_v_q |=> out_v_q)
    else $error("pixel lost before output register");
`endif

endmodule

// ----- dv/hob_overlay_checker.sv -----
// ----------------------------------------------------------------------------
// hob_overlay_checker
// Watches the register port and both item channels of the heatmap overlay
// blend block, predicts every output pixel from its own copy of the grid,
// raster counters and registers, and compares accepted results in order.
// ----------------------------------------------------------------------------
module hob_overlay_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               req_type_i,
  input  logic [9:0]         cell_index_i,
  input  logic signed [31:0] intensity_i,
  input  logic [15:0]        pixel_i,
  input  logic               frame_start_i,
  // output channel
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [15:0]        pixel_out_i,
  // status to the testbench top
  output int                 fail_count_o,
  output int                 pending_o
);
  import hob_pkg::*;

  localparam int unsigned CELLS = GRID_CELLS_DEF;

  hob_cfg_t           regs;
  logic signed [31:0] cell_level [CELLS];
  int unsigned        col, row, grid_col, off_x, grid_row, off_y;
  logic [15:0]        expected_pixels [$];

  // colour of an intensity level blended into one pixel
  function automatic logic [15:0] overlay_pixel(logic [15:0] pix, logic signed [31:0] level);
    longint      span;
    longint      ceiling;
    int unsigned n, a, mr, mg, mb, pr, pg, pb, r, g, b;
    span    = longint'(level) - longint'($signed(regs.level_floor));
    ceiling = (longint'(1) << regs.range_scale) - 1;
    if (span > ceiling) span = ceiling;
    if (regs.range_scale < 8) n = int'((span << (8 - regs.range_scale)) & 255);
    else n = int'((span >> (regs.range_scale - 8)) & 255);
    mr = (n > 127) ? (n - 127) >> 2 : 0;
    mg = (n < 128) ? n >> 1 : (255 - n) >> 1;
    mb = (n < 128) ? (127 - n) >> 2 : 0;
    a  = (regs.alpha > 256) ? 256 : regs.alpha;
    pr = pix[15:11];
    pg = pix[10:5];
    pb = pix[4:0];
    r  = ((256 - a) * mr + a * pr) >> 8;
    g  = ((256 - a) * mg + a * pg) >> 8;
    b  = ((256 - a) * mb + a * pb) >> 8;
    // red of 32 loses its top bit in the 16-bit pack
    return 16'((r << 11) | (g << 5) | b);
  endfunction

  // result for a pixel at the current raster position
  function automatic logic [15:0] shaded_pixel(logic [15:0] pix);
    int unsigned idx;
    logic [15:0] res;
    res = pix;
    if (grid_col < regs.grid_width && grid_row < regs.grid_height) begin
      idx = grid_row * regs.grid_width + grid_col;
      if (idx < CELLS && $signed(cell_level[idx]) >= $signed(regs.level_floor))
        res = overlay_pixel(pix, cell_level[idx]);
    end
    return res;
  endfunction

  function automatic int unsigned sat_bump(int unsigned v);
    return (v >= 63) ? 63 : v + 1;
  endfunction

  // raster counter advance after each pixel
  task automatic step_raster();
    if (col + 1 >= regs.frame_width) begin
      col      = 0;
      off_x    = 0;
      grid_col = 0;
      row      = (row + 1) & 12'hFFF;
      if (off_y + 1 >= regs.cell_height) begin
        off_y    = 0;
        grid_row = sat_bump(grid_row);
      end else begin
        off_y++;
      end
    end else begin
      col++;
      if (off_x + 1 >= regs.cell_width) begin
        off_x    = 0;
        grid_col = sat_bump(grid_col);
      end else begin
        off_x++;
      end
    end
  endtask

  task automatic clear_raster();
    col      = 0;
    row      = 0;
    grid_col = 0;
    off_x    = 0;
    grid_row = 0;
    off_y    = 0;
  endtask

  // register writes, item prediction and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      regs.frame_width = RST_FRAME_WIDTH;
      regs.cell_width  = RST_CELL_WIDTH;
      regs.cell_height = RST_CELL_HEIGHT;
      regs.grid_width  = RST_GRID_WIDTH;
      regs.grid_height = RST_GRID_HEIGHT;
      regs.level_floor = RST_LEVEL_FLOOR;
      regs.range_scale = RST_RANGE_SCALE;
      regs.alpha       = RST_ALPHA;
      clear_raster();
      expected_pixels.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (hob_cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH: regs.frame_width = cfg_data_i[11:0];
          CFG_CELL_WIDTH:  regs.cell_width  = cfg_data_i[7:0];
          CFG_CELL_HEIGHT: regs.cell_height = cfg_data_i[7:0];
          CFG_GRID_WIDTH:  regs.grid_width  = cfg_data_i[5:0];
          CFG_GRID_HEIGHT: regs.grid_height = cfg_data_i[5:0];
          CFG_LEVEL_FLOOR: regs.level_floor = cfg_data_i;
          CFG_RANGE_SCALE: regs.range_scale = cfg_data_i[4:0];
          CFG_ALPHA:       regs.alpha       = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (hob_req_e'(req_type_i) == REQ_LOAD) begin
          cell_level[cell_index_i] = intensity_i;
        end else begin
          if (frame_start_i) clear_raster();
          expected_pixels.push_back(shaded_pixel(pixel_i));
          step_raster();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: expected none, actual %h", pixel_out_i);
          fail_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out_i !== want) begin
            $error("pixel_out: expected %h, actual %h", want, pixel_out_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- dv/tb_heatmap_overlay_blend.sv -----
// ----------------------------------------------------------------------------
// tb_heatmap_overlay_blend
// Drives load and pixel items into the heatmap overlay blend block under
// random input gaps and output stalls, across several register settings,
// and leaves prediction and comparison to the overlay checker.
// ----------------------------------------------------------------------------
module tb_heatmap_overlay_blend;
  import hob_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  hob_cfg_idx_e       cfg_idx;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [9:0]         cell_index;
  logic signed [31:0] intensity;
  logic [15:0]        pixel;
  logic               frame_start;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        pixel_out;
  int                 fails;
  int                 pending;

  // register values as last written, used to shape the stimulus
  int unsigned        cur_fw, cur_ch, cur_gw, cur_gh, cur_rs;
  logic signed [31:0] cur_nb;
  logic               gaps_on;

  heatmap_overlay_blend u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .valid_i      (in_valid),
    .stall_o      (in_stall),
    .req_type_i   (req_type),
    .cell_index_i (cell_index),
    .intensity_i  (intensity),
    .pixel_i      (pixel),
    .frame_start_i(frame_start),
    .valid_o      (out_valid),
    .stall_i      (out_stall),
    .pixel_out_o  (pixel_out)
  );

  hob_overlay_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .cell_index_i (cell_index),
    .intensity_i  (intensity),
    .pixel_i      (pixel),
    .frame_start_i(frame_start),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_i  (pixel_out),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1600000;
    $display("tb_heatmap_overlay_blend: errors");
    $finish;
  end

  // output stalls: short bursts mostly, now and then a long one
  initial begin
    int run;
    int len;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 12);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      @(negedge clk_i);
      out_stall <= 1'b0;
      repeat (run) @(negedge clk_i);
      @(negedge clk_i);
      out_stall <= 1'b1;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // intensity near the current floor, now and then anywhere
  function automatic logic [31:0] pick_level();
    longint span;
    longint v;
    span = longint'(1) << cur_rs;
    if ($urandom_range(0, 9) == 0) return $urandom;
    v = longint'(cur_nb) + longint'($urandom_range(0, 32'(span + span / 2))) - span / 4;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  function automatic logic [9:0] pick_cell();
    if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, cur_gw * cur_gh - 1));
  endfunction

  task automatic set_reg(hob_cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: cur_fw = val[11:0];
      CFG_CELL_HEIGHT: cur_ch = val[7:0];
      CFG_GRID_WIDTH:  cur_gw = val[5:0];
      CFG_GRID_HEIGHT: cur_gh = val[5:0];
      CFG_LEVEL_FLOOR: cur_nb = val;
      CFG_RANGE_SCALE: cur_rs = val[4:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int unsigned fw, int unsigned cw, int unsigned ch,
                              int unsigned gw, int unsigned gh, logic [31:0] nb,
                              int unsigned rs, int unsigned al);
    set_reg(CFG_FRAME_WIDTH, fw);
    set_reg(CFG_CELL_WIDTH, cw);
    set_reg(CFG_CELL_HEIGHT, ch);
    set_reg(CFG_GRID_WIDTH, gw);
    set_reg(CFG_GRID_HEIGHT, gh);
    set_reg(CFG_LEVEL_FLOOR, nb);
    set_reg(CFG_RANGE_SCALE, rs);
    set_reg(CFG_ALPHA, al);
  endtask

  // lower valid, wait for every pixel to come back, then let loads settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_item(hob_req_e req, logic [9:0] idx, logic [31:0] level,
                           logic [15:0] pix, logic fs);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid    <= 1'b1;
    req_type    <= req;
    cell_index  <= idx;
    intensity   <= level;
    pixel       <= pix;
    frame_start <= fs;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic load_cell(logic [9:0] idx, logic [31:0] level, logic fs);
    send_item(REQ_LOAD, idx, level, 16'($urandom), fs);
  endtask

  task automatic send_pixel(logic [15:0] pix, logic fs);
    send_item(REQ_PIXEL, 10'($urandom), $urandom, pix, fs);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned fw, cw, ch, frame_len, in_frame;
    logic        fs;
    logic        fresh;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_FRAME_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    req_type    = REQ_LOAD;
    cell_index  = '0;
    intensity   = '0;
    pixel       = '0;
    frame_start = 1'b0;
    gaps_on     = 1'b1;
    cur_fw      = RST_FRAME_WIDTH;
    cur_ch      = RST_CELL_HEIGHT;
    cur_gw      = RST_GRID_WIDTH;
    cur_gh      = RST_GRID_HEIGHT;
    cur_nb      = RST_LEVEL_FLOOR;
    cur_rs      = RST_RANGE_SCALE;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the cells that random grids of up to 16 by 16 can reach
    for (int i = 0; i < 256; i++) load_cell(10'(i), $urandom, 1'b0);

    // small grid, pure colormap: red overflow, quiet cell, blue end, clamp
    wait_idle();
    program_regs(3, 1, 1, 2, 2, 32'sd0, 8, 0);
    load_cell(10'd0, 32'sd255, 1'b0);
    load_cell(10'd1, -32'sd1, 1'b0);
    load_cell(10'd2, 32'sd0, 1'b0);
    load_cell(10'd3, 32'sd5000, 1'b0);
    // frame start on a load has no effect on the counters
    load_cell(10'd1023, 32'h8000_0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h1234, 1'b0);

    // zero sizes, wide grid running past the store, widest span, alpha over full
    wait_idle();
    program_regs(0, 0, 0, 63, 32, 32'h8000_0000, 31, 300);
    load_cell(10'd0, 32'h7FFF_FFFF, 1'b0);
    // first cell of each grid row that the pixels below walk through
    for (int k = 1; k < 17; k++) load_cell(10'(k * 63), $urandom, 1'b0);
    for (int k = 0; k < 18; k++) send_pixel(16'($urandom), k == 0);
    wait_idle();
    set_reg(CFG_ALPHA, 64);
    set_reg(CFG_RANGE_SCALE, 0);
    send_pixel(16'($urandom), 1'b1);
    wait_idle();
    set_reg(CFG_LEVEL_FLOOR, 32'h7FFF_FFFF);
    send_pixel(16'($urandom), 1'b1);

    // random phases: raster frames with loads mixed in
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) begin
        program_regs(4095, 255, 255, 32, 32, 32'h8000_0000, 24, 256);
      end else if (ph == 1) begin
        program_regs(1, 1, 1, 1, 1, 32'h7FFF_FFFF, 1, 0);
      end else begin
        fw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 48);
        cw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
        ch = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
        program_regs(fw, cw, ch, $urandom_range(1, 16), $urandom_range(1, 16),
                     ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2000)) - 1000,
                     $urandom_range(1, 24), $urandom_range(0, 256));
      end
      gaps_on   = (ph % 3) != 2;
      frame_len = cur_fw * (cur_ch * cur_gh + 1);
      if (frame_len > 240) frame_len = 240;
      fresh     = 1'b1;
      in_frame  = 0;
      for (int k = 0; k < 106; k++) begin
        if ($urandom_range(0, 99) == 0) wait_idle();
        if ($urandom_range(0, 3) == 0) begin
          load_cell(pick_cell(), pick_level(), 1'($urandom_range(0, 1)));
        end else begin
          fs = fresh || in_frame >= frame_len || $urandom_range(0, 49) == 0;
          send_pixel(16'($urandom), fs);
          in_frame = fs ? 1 : in_frame + 1;
          fresh    = 1'b0;
        end
      end
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("tb_heatmap_overlay_blend: clean");
    end else begin
      $display("tb_heatmap_overlay_blend: errors");
    end
    $finish;
  end

endmodule
